>>> rtl/core/rsmp_pkg.sv
// Shared types and constants of the linear interpolation resampler.
// No dependencies; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rsmp_pkg;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 20;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Phase step minimum and reset value
  localparam logic [STEP_W-1:0] STEP_MIN   = 20'd1024;
  localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;

  // Fraction bits of the phase accumulator
  localparam int PHASE_FRAC_BITS_DEF = 16;

  // Results per input item are capped
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 8'd1;

  // What the back end does with a queued item
  typedef enum logic [1:0] {
    KIND_BYPASS,
    KIND_PRIME,
    KIND_INTERP
  } kind_t;

  typedef struct packed {
    kind_t                       kind;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        blk;
  } q_item_t;

  // Settings and clear pulse handed from front to back
  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              clear;
  } ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/rsmp_if.sv
// Valid/ready channel interfaces of the resampler: input, result, configuration.
// Depends on rsmp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rsmp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rsmp_pkg::SAMPLE_W-1:0] sample_in;
  logic                                 block_end;

  modport source (output valid, output sample_in, output block_end, input ready);
  modport sink   (input valid, input sample_in, input block_end, output ready);
endinterface

interface rsmp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rsmp_pkg::SAMPLE_W-1:0] sample_out;
  logic                                 last_of_run;
  logic                                 flush;

  modport source (output valid, output sample_out, output last_of_run, output flush,
                  input ready);
  modport sink   (input valid, input sample_out, input last_of_run, input flush,
                  output ready);
endinterface

interface rsmp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rsmp_pkg::CFG_IDX_W-1:0]     index;
  logic [rsmp_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rsmp_front.sv
// Front end: configuration registers, input accept and item classification.
// Depends on rsmp_pkg and the channel interfaces in rsmp_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module rsmp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rsmp_in_if.sink                in_if,
  rsmp_cfg_if.sink               cfg_if,
  input  wire logic              q_full,
  output rsmp_pkg::q_item_t      q_data,
  output logic                   q_push,
  output rsmp_pkg::ctl_t         ctl
);

  logic [rsmp_pkg::STEP_W-1:0] step_r;
  logic                        bypass_r;
  logic                        primed_r;
  logic [rsmp_pkg::STEP_W-1:0] step_wr;
  logic                        cfg_hit;

  // Configuration writes are always taken
  assign cfg_if.ready = 1'b1;
  assign cfg_hit = cfg_if.valid &&
                   ((cfg_if.index == rsmp_pkg::REG_STEP) ||
                    (cfg_if.index == rsmp_pkg::REG_BYPASS));

  // Clamp a written step to its minimum
  always_comb begin
    step_wr = cfg_if.data[rsmp_pkg::STEP_W-1:0];
    if (step_wr < rsmp_pkg::STEP_MIN) begin
      step_wr = rsmp_pkg::STEP_MIN;
    end
  end

  // Accept an item whenever the queue has room
  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  // Classify the item against the current mode and priming state
  always_comb begin
    q_data.sample = in_if.sample_in;
    q_data.blk    = in_if.block_end;
    if (bypass_r) begin
      q_data.kind = rsmp_pkg::KIND_BYPASS;
    end else if (!primed_r) begin
      q_data.kind = rsmp_pkg::KIND_PRIME;
    end else begin
      q_data.kind = rsmp_pkg::KIND_INTERP;
    end
  end

  assign ctl.step  = step_r;
  assign ctl.clear = cfg_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= rsmp_pkg::STEP_RESET;
      bypass_r <= 1'b1;
      primed_r <= 1'b0;
    end else if (cfg_hit) begin
      // A write to either mapped register drops the priming
      if (cfg_if.index == rsmp_pkg::REG_STEP) begin
        step_r <= step_wr;
      end else begin
        bypass_r <= cfg_if.data[0];
      end
      primed_r <= 1'b0;
    end else if (q_push && (q_data.kind == rsmp_pkg::KIND_PRIME)) begin
      primed_r <= 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rsmp_fifo.sv
// Short item queue between the front and the back end of the resampler.
// Depends on rsmp_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module rsmp_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rsmp_pkg::q_item_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output rsmp_pkg::q_item_t      head_data
);

  localparam int DEPTH = rsmp_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  rsmp_pkg::q_item_t mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r;
  logic [AW-1:0]     rd_ptr_r;
  logic [CW-1:0]     cnt_r;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

>>> rtl/core/rsmp_back.sv
// Back end: phase sequencer, interpolation multiply stage and result register.
// Depends on rsmp_pkg and the result channel interface in rsmp_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module rsmp_back #(
  parameter int PHASE_FRAC_BITS = rsmp_pkg::PHASE_FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire rsmp_pkg::q_item_t head_data,
  output logic                   pop,
  input  wire rsmp_pkg::ctl_t    ctl,
  rsmp_out_if.source             out_if
);

  localparam int SW    = rsmp_pkg::SAMPLE_W;
  localparam int F     = PHASE_FRAC_BITS;
  localparam int PW    = ((F > rsmp_pkg::STEP_W) ? F : rsmp_pkg::STEP_W) + 1;
  localparam int PRODW = SW + 1 + F + 1;
  localparam int CW    = rsmp_pkg::CNT_W;
  localparam logic [PW-1:0] PHASE_ONE = {{(PW-1){1'b0}}, 1'b1} << F;
  localparam logic [CW-1:0] CNT_MAX   = CW'(rsmp_pkg::MAX_RESULTS);

  // Sequencer state
  logic [PW-1:0]          phase_r, phase_nxt;
  logic signed [SW-1:0]   prev_r, prev_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;

  // Multiply stage
  logic                   m_valid_r;
  logic signed [PRODW-1:0] m_prod_r;
  logic signed [SW-1:0]   m_s0_r;
  logic                   m_last_r;
  logic                   m_flush_r;

  // Result register
  logic                   out_valid_r;
  logic signed [SW-1:0]   out_sample_r;
  logic                   out_last_r;
  logic                   out_flush_r;

  logic                   out_free;
  logic                   m_free;
  logic                   issue;
  logic signed [SW-1:0]   iss_s0;
  logic signed [SW-1:0]   iss_cur;
  logic [F-1:0]           iss_b;
  logic                   iss_last;
  logic                   iss_flush;
  logic [PW-1:0]          step_ext;
  logic [PW-1:0]          phase_sum;
  logic signed [SW:0]     delta;
  logic signed [F:0]      mul_b;
  logic signed [PRODW-1:0] prod;
  logic signed [PRODW-1:0] prod_sh;
  logic signed [SW:0]     res_sum;

  assign out_free  = !out_valid_r || out_if.ready;
  assign m_free    = !m_valid_r || out_free;
  assign step_ext  = {{(PW-rsmp_pkg::STEP_W){1'b0}}, ctl.step};
  assign phase_sum = phase_r + step_ext;

  // Sequence one queued item: prime, pass through, or walk the phase
  always_comb begin
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    cnt_nxt   = cnt_r;
    pop       = 1'b0;
    issue     = 1'b0;
    iss_s0    = prev_r;
    iss_cur   = head_data.sample;
    iss_b     = phase_r[F-1:0];
    iss_last  = 1'b0;
    iss_flush = 1'b0;
    if (head_valid) begin
      case (head_data.kind)
        rsmp_pkg::KIND_PRIME: begin
          prev_nxt = head_data.sample;
          pop      = 1'b1;
        end
        rsmp_pkg::KIND_BYPASS: begin
          iss_s0    = head_data.sample;
          iss_b     = '0;
          iss_last  = 1'b1;
          iss_flush = head_data.blk;
          if (m_free) begin
            issue = 1'b1;
            pop   = 1'b1;
          end
        end
        rsmp_pkg::KIND_INTERP: begin
          if (phase_r < PHASE_ONE) begin
            iss_last  = (cnt_r == CNT_MAX - 1'b1) || (phase_sum >= PHASE_ONE);
            iss_flush = iss_last && head_data.blk;
            if (cnt_r < CNT_MAX) begin
              if (m_free) begin
                issue     = 1'b1;
                phase_nxt = phase_sum;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end else begin
              // Past the cap: advance the phase without a result
              phase_nxt = phase_sum;
            end
          end else begin
            // Wrap the phase and retire the sample
            phase_nxt = phase_r - PHASE_ONE;
            prev_nxt  = head_data.sample;
            cnt_nxt   = '0;
            pop       = 1'b1;
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
    if (ctl.clear) begin
      phase_nxt = '0;
    end
  end

  // Interpolation product
  assign delta = {iss_cur[SW-1], iss_cur} - {iss_s0[SW-1], iss_s0};
  assign mul_b = {1'b0, iss_b};
  assign prod  = delta * mul_b;

  // Floor shift and add back the earlier sample
  assign prod_sh = m_prod_r >>> F;
  assign res_sum = {m_s0_r[SW-1], m_s0_r} + prod_sh[SW:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      prev_r      <= '0;
      cnt_r       <= '0;
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      cnt_r   <= cnt_nxt;
      if (m_free) begin
        m_valid_r <= issue;
      end
      if (out_free) begin
        out_valid_r <= m_valid_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (issue) begin
      m_prod_r  <= prod;
      m_s0_r    <= iss_s0;
      m_last_r  <= iss_last;
      m_flush_r <= iss_flush;
    end
    if (out_free && m_valid_r) begin
      out_sample_r <= res_sum[SW-1:0];
      out_last_r   <= m_last_r;
      out_flush_r  <= m_flush_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.sample_out  = out_sample_r;
  assign out_if.last_of_run = out_last_r;
  assign out_if.flush       = out_flush_r;

`ifndef SYNTHESIS
  a_cnt_capped: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("result count past cap");

  a_phase_after_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (head_data.kind == rsmp_pkg::KIND_INTERP) && !ctl.clear)
      |=> (phase_r < step_ext))
    else $error("phase not below step after wrap");

  a_mul_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (m_valid_r && !out_free) |=> (m_valid_r && $stable(m_prod_r)))
    else $error("multiply stage lost a stalled result");
`endif

endmodule

`default_nettype wire

>>> rtl/core/linear_interp_resampler.sv
// Top level of the linear interpolation resampler: front, queue and back end.
// Depends on rsmp_pkg, rsmp_if.sv, rsmp_front, rsmp_fifo and rsmp_back.
//
// Usage:
//   in_if  : one signed 16-bit sample per item plus a block_end mark.
//   out_if : interpolated samples, with last_of_run on the final result of an
//            input item and flush on that result when the input had block_end.
//   cfg_if : register writes, always ready; index 0 is the Q step (clamped to
//            at least 1024), index 1 is bypass. A write to either re-primes the block.
//   Write configuration only while no item is in flight.
// Path: two-entry queue, sequencer, multiply stage, result register.
// Sequencing: the back end pops a priming item, issues one result for
//   a bypass item, and issues an interpolated item's n results, one per phase
//   step (at most 64 at the minimum step), then wraps the phase; with more
//   than 16 fraction bits, phase steps past the 64-result cap issue nothing.
//   Issues wait on a held multiply stage; the phase sequencer sets the pace.
// Reset: step 65536, bypass on, phase and priming cleared; no clearing pass.
// Stall: a stalled receiver holds the result register, then the multiply
//   stage, then the sequencer; the queue fills and in_if.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module linear_interp_resampler #(
  parameter int PHASE_FRAC_BITS = rsmp_pkg::PHASE_FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rsmp_in_if.sink    in_if,
  rsmp_out_if.source out_if,
  rsmp_cfg_if.sink   cfg_if
);

  rsmp_pkg::q_item_t q_push_data;
  rsmp_pkg::q_item_t q_head_data;
  rsmp_pkg::ctl_t    ctl;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_head_valid;

  rsmp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .q_full (q_full),
    .q_data (q_push_data),
    .q_push (q_push),
    .ctl    (ctl)
  );

  rsmp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data)
  );

  rsmp_back #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_data  (q_head_data),
    .pop        (q_pop),
    .ctl        (ctl),
    .out_if     (out_if)
  );

endmodule

`default_nettype wire

>>> bench/linear_interp_resampler_test.sv
// Self-checking bench for linear_interp_resampler: drives samples, register writes and
// random stalls, and predicts every interpolated result. Needs rsmp_pkg and rsmp_if.sv.
`timescale 1ns / 1ps

module linear_interp_resampler_test;

  localparam int FRAC_BITS = rsmp_pkg::PHASE_FRAC_BITS_DEF;
  localparam longint PHASE_ONE = longint'(1) << FRAC_BITS;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS = 280;
  localparam int MAX_PRINTED = 40;

  // Register indexes outside the map; writes to them must change nothing
  localparam logic [rsmp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
  localparam logic [rsmp_pkg::CFG_IDX_W-1:0] REG_TOP = 8'hFF;

  typedef struct packed {
    logic signed [rsmp_pkg::SAMPLE_W-1:0] sample;
    logic                                 last;
    logic                                 flush;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  rsmp_in_if  in_ch();
  rsmp_out_if out_ch();
  rsmp_cfg_if cfg_ch();

  linear_interp_resampler #(
    .PHASE_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  always #1 clk = ~clk;

  // Shadow copy of the block's registers and interpolation state
  logic [rsmp_pkg::STEP_W-1:0]          step_reg;
  logic                                 bypass_reg;
  longint                               phase_acc;
  logic signed [rsmp_pkg::SAMPLE_W-1:0] prev_sample;
  logic                                 primed;

  result_t due_samples[$];

  int  errors = 0;
  int  cycles = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  int  rx_hold = 0;

  // Return every register and state to its reset value
  function automatic void reset_shadow();
    step_reg    = rsmp_pkg::STEP_RESET;
    bypass_reg  = 1'b1;
    phase_acc   = 0;
    prev_sample = '0;
    primed      = 1'b0;
  endfunction

  // Mirror one register write: clamp the step, re-prime on any known index
  function automatic void apply_reg_write(input logic [rsmp_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [rsmp_pkg::CFG_DATA_W-1:0] val);
    logic [rsmp_pkg::STEP_W-1:0] s;
    s = val[rsmp_pkg::STEP_W-1:0];
    case (idx)
      rsmp_pkg::REG_STEP: begin
        step_reg  = (s < rsmp_pkg::STEP_MIN) ? rsmp_pkg::STEP_MIN : s;
        phase_acc = 0;
        primed    = 1'b0;
      end
      rsmp_pkg::REG_BYPASS: begin
        bypass_reg = val[0];
        phase_acc  = 0;
        primed     = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  // Queue the samples one input item yields; mark the final one of the run
  function automatic void resample(input logic signed [rsmp_pkg::SAMPLE_W-1:0] cur,
                                   input logic blk);
    result_t held;
    bit      have;
    int      n;
    longint  term;
    have = 1'b0;
    n = 0;
    if (bypass_reg) begin
      held.sample = cur;
      held.last   = 1'b1;
      held.flush  = blk;
      due_samples.push_back(held);
      return;
    end
    if (!primed) begin
      prev_sample = cur;
      primed      = 1'b1;
      return;
    end
    while (phase_acc < PHASE_ONE) begin
      if (n < rsmp_pkg::MAX_RESULTS) begin
        if (have) due_samples.push_back(held);
        // arithmetic shift of a signed product rounds toward minus infinity
        term = ((longint'(cur) - longint'(prev_sample)) * phase_acc) >>> FRAC_BITS;
        held.sample = (rsmp_pkg::SAMPLE_W)'(longint'(prev_sample) + term);
        held.last   = 1'b0;
        held.flush  = 1'b0;
        have = 1'b1;
        n++;
      end
      phase_acc += longint'(step_reg);
    end
    phase_acc -= PHASE_ONE;
    prev_sample = cur;
    if (have) begin
      held.last  = 1'b1;
      held.flush = blk;
      due_samples.push_back(held);
    end
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // Compare one accepted result with the oldest pending one
  task automatic check_result(input result_t got);
    result_t want;
    if (due_samples.size() == 0) begin
      report_mismatch($sformatf("result %0d with nothing pending", got.sample));
      return;
    end
    want = due_samples.pop_front();
    if (got.sample !== want.sample)
      report_mismatch($sformatf("sample_out %0d, want %0d", got.sample, want.sample));
    if (got.last !== want.last)
      report_mismatch($sformatf("last_of_run %b, want %b", got.last, want.last));
    if (got.flush !== want.flush)
      report_mismatch($sformatf("flush %b, want %b", got.flush, want.flush));
  endtask

  // Offer one item, after a random gap while tx_idle is set; leave valid high for a following item
  task automatic send_sample(input logic signed [rsmp_pkg::SAMPLE_W-1:0] s,
                             input logic blk);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= s;
    in_ch.block_end <= blk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    resample(s, blk);
  endtask

  // Drop valid, wait for every pending result, then let zero-result items finish
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rsmp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rsmp_pkg::CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    apply_reg_write(idx, val);
  endtask

  // Next random sample: full range, a small step from the last one, or an extreme
  function automatic logic signed [rsmp_pkg::SAMPLE_W-1:0] pick_sample(
      input logic signed [rsmp_pkg::SAMPLE_W-1:0] last_s);
    case ($urandom_range(0, 5))
      0, 1:    return (rsmp_pkg::SAMPLE_W)'($urandom);
      2, 3, 4: return last_s + (rsmp_pkg::SAMPLE_W)'($urandom_range(0, 127))
                      - (rsmp_pkg::SAMPLE_W)'(64);
      default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  // Reset leaves bypass on: extremes and alternating bit patterns pass through
  task automatic test_bypass_passthrough();
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'shFFFF, 1'b1);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'sh5555, 1'b1);
    send_sample(16'shAAAA, 1'b0);
  endtask

  // Priming hides block_end; unmapped indexes keep phase and priming intact
  task automatic test_register_writes();
    write_reg(rsmp_pkg::REG_BYPASS, 32'hFFFF_FFFE);
    write_reg(rsmp_pkg::REG_STEP, 32'h0001_0000);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b1);
    write_reg(REG_UNUSED, 32'h0000_0000);
    write_reg(REG_TOP, 32'hFFFF_FFFF);
    send_sample(16'sh8000, 1'b0);
  endtask

  // Step clamping at the minimum, the largest step, full-scale deltas and rounding of negative terms
  task automatic test_step_extremes();
    write_reg(rsmp_pkg::REG_STEP, 32'h0000_03FF);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    write_reg(rsmp_pkg::REG_STEP, 32'h0000_8000);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'shFFFF, 1'b0);
    send_sample(16'sh0001, 1'b1);
    write_reg(rsmp_pkg::REG_STEP, 32'hFFFF_FFFF);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd200, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    write_reg(rsmp_pkg::REG_STEP, 32'hFFF0_0000);
    send_sample(16'sh1234, 1'b0);
    send_sample(16'shEDCB, 1'b1);
  endtask

  // Phases of random settings, each followed by a run of random samples
  task automatic test_random_rates();
    int sent;
    int n_items;
    logic [rsmp_pkg::CFG_DATA_W-1:0] step_val;
    logic bypass_val;
    logic signed [rsmp_pkg::SAMPLE_W-1:0] s;
    sent = 0;
    s = '0;
    while (sent < RANDOM_ITEMS) begin
      bypass_val = 1'b0;
      case ($urandom_range(0, 9))
        0: begin
          step_val = $urandom_range(0, 1100);
          n_items = $urandom_range(3, 8);
        end
        1: begin
          step_val = {12'($urandom), 20'hFFFFF};
          n_items = $urandom_range(30, 50);
        end
        2: begin
          step_val = $urandom;
          n_items = $urandom_range(10, 30);
        end
        3: begin
          step_val = $urandom;
          bypass_val = 1'b1;
          n_items = $urandom_range(10, 30);
        end
        default: begin
          step_val = $urandom_range(2048, 131072);
          n_items = $urandom_range(10, 30);
        end
      endcase
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) begin
        write_reg(rsmp_pkg::REG_STEP, step_val);
        write_reg(rsmp_pkg::REG_BYPASS, {31'($urandom), bypass_val});
      end else begin
        write_reg(rsmp_pkg::REG_BYPASS, {31'($urandom), bypass_val});
        write_reg(rsmp_pkg::REG_STEP, step_val);
      end
      repeat (n_items) begin
        s = pick_sample(s);
        send_sample(s, $urandom_range(0, 7) == 0);
        sent++;
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Hold the receiver off while items keep coming, so the queue fills
  task automatic test_input_backpressure();
    logic signed [rsmp_pkg::SAMPLE_W-1:0] s;
    s = '0;
    write_reg(rsmp_pkg::REG_BYPASS, 32'h0);
    write_reg(rsmp_pkg::REG_STEP, 32'h0000_0800);
    tx_idle = 1'b0;
    rx_hold = 300;
    repeat (16) begin
      s = pick_sample(s);
      send_sample(s, $urandom_range(0, 3) == 0);
    end
    tx_idle = 1'b1;
    wait_drained();
  endtask

  // Result side: random stalls, one long hold on request, check each item
  initial begin : result_sink
    result_t got;
    int      stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = rx_idle ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got = {out_ch.sample_out, out_ch.last_of_run, out_ch.flush};
      check_result(got);
    end
  end

  // Abort a hung run
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** linear_interp_resampler: FAILED **");
    $finish;
  end

  initial begin : stimulus
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.sample_in <= '0;
    in_ch.block_end <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    reset_shadow();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bypass_passthrough();
    test_register_writes();
    test_step_extremes();
    test_random_rates();
    test_input_backpressure();
    wait_drained();

    if (errors == 0) begin
      $display("** linear_interp_resampler: PASSED **");
    end else begin
      $display("** linear_interp_resampler: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/rsmp_pkg.sv
rtl/core/rsmp_if.sv
rtl/core/rsmp_front.sv
rtl/core/rsmp_fifo.sv
rtl/core/rsmp_back.sv
rtl/core/linear_interp_resampler.sv
bench/linear_interp_resampler_test.sv
